/* rtl/core/lnc_pkg.sv */
// ----------------------------------------------------------------------------
// lnc_pkg: shared types and constants for the line clip and projection core
// Beat payloads, queue entry, config bundle, register indexes and reset values.
// ----------------------------------------------------------------------------
package lnc_pkg;

    // Fraction bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Normalized device coordinates clamp at 2^40
    localparam int NDC_LIMIT_LOG2 = 40;
    localparam int NDC_W          = NDC_LIMIT_LOG2 + 2;

    // Input command codes
    localparam logic [1:0] CMD_LOAD_VIEW = 2'd0;
    localparam logic [1:0] CMD_LOAD_PROJ = 2'd1;
    localparam logic [1:0] CMD_DRAW      = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_NEAR   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Register reset values
    localparam logic [30:0] NEAR_RESET   = 31'd655;
    localparam logic [13:0] WIDTH_RESET  = 14'd1920;
    localparam logic [13:0] HEIGHT_RESET = 14'd1080;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Kind of work carried through the queue and the back pipeline
    typedef enum logic [1:0] {
        K_VIEW,
        K_PROJ,
        K_DRAW
    } t_kind;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         element_index;
        logic signed [31:0] element_value;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic [23:0]        color_rgb;
        logic [30:0]        line_width;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] screen_start_x;
        logic signed [31:0] screen_start_y;
        logic signed [31:0] screen_end_x;
        logic signed [31:0] screen_end_y;
        logic [31:0]        packed_color;
        logic [30:0]        out_width;
    } t_out_item;

    // Classified entry between front and back
    typedef struct packed {
        t_kind            kind;
        logic [3:0]       idx;
        logic [31:0]      value;
        logic [2:0][31:0] pa;
        logic [2:0][31:0] pb;
        logic [23:0]      color;
        logic [30:0]      lw;
    } t_qent;

    // Configuration registers as seen by the back pipeline
    typedef struct packed {
        logic [30:0] near_distance;
        logic [13:0] display_width;
        logic [13:0] display_height;
    } t_cfg;

endpackage

/* rtl/core/line_near_clip_and_screen_project_core.sv */
// ----------------------------------------------------------------------------
// line_near_clip_and_screen_project_core: near-plane line clip and projection
// Loads view/projection matrices, clips lines at the near plane and maps them
// to screen pixels in signed fixed point.
// ----------------------------------------------------------------------------
// The core takes one beat per cycle, matrix loads and lines alike, and keeps
// that rate as long as the output side is not stalled. A line passes through
// the front holding register, the four-entry queue and the back pipeline,
// whose depth comes mostly from two bit-per-stage dividers, one for the clip
// parameter (FRAC_BITS stages) and one for the perspective divide
// (32 + FRAC_BITS stages). Loads and dropped lines give no output beat.
// A stall on the output freezes the whole geometry pipe; the four-entry
// queue in front keeps accepting until it fills. Config registers are at
// byte addresses 0 (near distance), 4 (width) and 8 (height) and are to be
// written only while the core is idle.
// ----------------------------------------------------------------------------
module line_near_clip_and_screen_project_core #(
    parameter int FRAC_BITS = lnc_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lnc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output lnc_pkg::t_out_item o_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic           push;
    logic           q_full;
    lnc_pkg::t_qent f_ent;
    logic           q_valid;
    logic           q_pop;
    lnc_pkg::t_qent q_ent;
    lnc_pkg::t_cfg  r_cfg;

    // config registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_distance  <= lnc_pkg::NEAR_RESET;
            r_cfg.display_width  <= lnc_pkg::WIDTH_RESET;
            r_cfg.display_height <= lnc_pkg::HEIGHT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                lnc_pkg::REG_NEAR:   r_cfg.near_distance  <= pwdata[30:0];
                lnc_pkg::REG_WIDTH:  r_cfg.display_width  <= pwdata[13:0];
                lnc_pkg::REG_HEIGHT: r_cfg.display_height <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lnc_pkg::REG_NEAR:   prdata = {1'b0, r_cfg.near_distance};
            lnc_pkg::REG_WIDTH:  prdata = {18'd0, r_cfg.display_width};
            lnc_pkg::REG_HEIGHT: prdata = {18'd0, r_cfg.display_height};
            default:             prdata = '0;
        endcase
    end

    lnc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (push),
        .o_ent    (f_ent)
    );

    lnc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (f_ent),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_ent   (q_ent)
    );

    lnc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_ent   (q_ent),
        .o_q_pop   (q_pop),
        .i_cfg     (r_cfg),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

endmodule

/* rtl/core/lnc_front.sv */
// ----------------------------------------------------------------------------
// lnc_front: input stage
// Takes input beats, drops unused commands and builds queue entries.
// ----------------------------------------------------------------------------
module lnc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  lnc_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_push,
    output lnc_pkg::t_qent    o_ent
);

    logic           r_valid;
    lnc_pkg::t_qent r_ent;
    lnc_pkg::t_qent n_ent;
    logic           keep;
    logic           accept;

    assign o_push  = r_valid && !i_q_full;
    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_ent   = r_ent;

    // classify the command and repack the payload
    always_comb begin
        n_ent.idx   = i_item.element_index;
        n_ent.value = i_item.element_value;
        n_ent.pa    = {i_item.a_z, i_item.a_y, i_item.a_x};
        n_ent.pb    = {i_item.b_z, i_item.b_y, i_item.b_x};
        n_ent.color = i_item.color_rgb;
        n_ent.lw    = i_item.line_width;
        keep        = 1'b1;
        case (i_item.cmd)
            lnc_pkg::CMD_LOAD_VIEW: n_ent.kind = lnc_pkg::K_VIEW;
            lnc_pkg::CMD_LOAD_PROJ: n_ent.kind = lnc_pkg::K_PROJ;
            lnc_pkg::CMD_DRAW:      n_ent.kind = lnc_pkg::K_DRAW;
            default: begin
                n_ent.kind = lnc_pkg::K_DRAW;
                keep       = 1'b0;
            end
        endcase
    end

    // holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_push || !r_valid) begin
            r_valid <= accept && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent <= n_ent;
        end
    end

endmodule

/* rtl/core/lnc_fifo.sv */
// ----------------------------------------------------------------------------
// lnc_fifo: short queue between front and back
// Lets either side stall without holding up the other.
// ----------------------------------------------------------------------------
module lnc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lnc_pkg::t_qent i_ent,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output lnc_pkg::t_qent o_ent
);

    localparam int AW = $clog2(lnc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(lnc_pkg::QUEUE_DEPTH + 1);

    lnc_pkg::t_qent r_mem [lnc_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == CW'(lnc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(lnc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(lnc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

endmodule

/* rtl/core/lnc_udiv.sv */
// ----------------------------------------------------------------------------
// lnc_udiv: pipelined restoring divider
// One quotient bit per stage, several lanes sharing a valid and side payload.
// Remainder must start below the divisor.
// ----------------------------------------------------------------------------
module lnc_udiv #(
    parameter int LANES = 1,
    parameter int DW    = 32,
    parameter int QB    = 16,
    parameter int SW    = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [SW-1:0]               i_side,
    input  logic [LANES-1:0][DW-1:0]    i_rem0,
    input  logic [LANES-1:0][QB-1:0]    i_bits,
    input  logic [LANES-1:0][DW-1:0]    i_den,
    output logic                        o_valid,
    output logic [SW-1:0]               o_side,
    output logic [LANES-1:0][QB-1:0]    o_quo
);

    logic [LANES-1:0][DW-1:0] r_rem  [QB];
    logic [LANES-1:0][DW-1:0] r_den  [QB];
    logic [LANES-1:0][QB-1:0] r_bits [QB];
    logic [LANES-1:0][QB-1:0] r_quo  [QB];
    logic [SW-1:0]            r_side [QB];
    logic [QB-1:0]            r_v;

    logic [LANES-1:0][DW-1:0] n_rem  [QB];
    logic [LANES-1:0][QB-1:0] n_quo  [QB];

    // one trial subtract per stage and lane
    always_comb begin
        logic [DW-1:0] rp;
        logic [DW-1:0] dp;
        logic [QB-1:0] bp;
        logic [QB-1:0] qp;
        logic [DW:0]   trial;
        for (int s = 0; s < QB; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    rp = i_rem0[l];
                    dp = i_den[l];
                    bp = i_bits[l];
                    qp = '0;
                end else begin
                    rp = r_rem[s-1][l];
                    dp = r_den[s-1][l];
                    bp = r_bits[s-1][l];
                    qp = r_quo[s-1][l];
                end
                trial = {rp, bp[QB-1-s]};
                if (trial >= {1'b0, dp}) begin
                    n_rem[s][l] = DW'(trial - {1'b0, dp});
                    qp[QB-1-s]  = 1'b1;
                end else begin
                    n_rem[s][l] = trial[DW-1:0];
                end
                n_quo[s][l] = qp;
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QB-2:0], i_valid};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QB; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                if (s == 0) begin
                    r_den[s]  <= i_den;
                    r_bits[s] <= i_bits;
                    r_side[s] <= i_side;
                end else begin
                    r_den[s]  <= r_den[s-1];
                    r_bits[s] <= r_bits[s-1];
                    r_side[s] <= r_side[s-1];
                end
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_side  = r_side[QB-1];
    assign o_quo   = r_quo[QB-1];

endmodule

/* rtl/core/lnc_back.sv */
// ----------------------------------------------------------------------------
// lnc_back: geometry pipeline
// View transform, near-plane clip, projection, perspective divide and
// viewport mapping, one queue entry per cycle unless stalled. Matrix loads
// pass down the pipe and update each stage's private matrix copy in order with the lines.
// ----------------------------------------------------------------------------
module lnc_back #(
    parameter int FRAC_BITS = lnc_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  lnc_pkg::t_qent     i_q_ent,
    output logic               o_q_pop,
    input  lnc_pkg::t_cfg      i_cfg,
    output logic               o_valid,
    input  logic               i_stall,
    output lnc_pkg::t_out_item o_item
);

    localparam int TB = FRAC_BITS + 1;
    localparam int QB = 32 + FRAC_BITS;
    localparam int NW = lnc_pkg::NDC_W;
    localparam int MW = (QB > NW) ? QB : NW;
    localparam int LW = FRAC_BITS + 35;
    localparam int SW_ = NW + 15;
    localparam logic signed [31:0] ONE_FX  = 32'sd1 <<< FRAC_BITS;
    localparam logic [MW-1:0]      NDC_LIM = MW'(1) << lnc_pkg::NDC_LIMIT_LOG2;
    localparam logic signed [71:0] SAT_HI  = 72'sd2147483647;
    localparam logic signed [71:0] SAT_LO  = -72'sd2147483648;

    typedef enum logic [1:0] {
        T_ZERO,
        T_ONE,
        T_DIV
    } t_tsel;

    typedef struct packed {
        lnc_pkg::t_qent   ent;
        logic             a_out;
        logic             b_out;
        t_tsel            tsel;
        logic [2:0][32:0] d;
    } t_tside;

    typedef struct packed {
        logic [23:0] color;
        logic [30:0] lw;
        logic [3:0]  neg;
        logic [3:0]  wz;
        logic [3:0]  xneg;
    } t_nside;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        if (v > SAT_HI) begin
            return 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            return -32'sh8000_0000;
        end
        return $signed(v[31:0]);
    endfunction

    // floor each product, sum four terms, saturate
    function automatic logic signed [31:0] dot4(input logic signed [63:0] p0,
                                                input logic signed [63:0] p1,
                                                input logic signed [63:0] p2,
                                                input logic signed [63:0] p3);
        logic signed [71:0] acc;
        acc = 72'(p0 >>> FRAC_BITS) + 72'(p1 >>> FRAC_BITS)
            + 72'(p2 >>> FRAC_BITS) + 72'(p3 >>> FRAC_BITS);
        return sat32(acc);
    endfunction

    logic en;

    // matrix copies, one per reading stage
    logic signed [31:0] r_v1 [16];
    logic signed [31:0] r_v2 [16];
    logic signed [31:0] r_pm [16];

    // output register
    logic               r_out_valid;
    lnc_pkg::t_out_item r_out_item;

    assign en      = !r_out_valid || !i_stall;
    assign o_q_pop = en && i_q_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    // ---- stage 1: view z row products for both endpoints ----
    logic               r1_v;
    lnc_pkg::t_qent     r1_ent;
    logic signed [63:0] r1_pa [4];
    logic signed [63:0] r1_pb [4];
    logic signed [31:0] ha [4];
    logic signed [31:0] hb [4];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ha[c] = $signed(i_q_ent.pa[c]);
            hb[c] = $signed(i_q_ent.pb[c]);
        end
        ha[3] = ONE_FX;
        hb[3] = ONE_FX;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ent <= i_q_ent;
            for (int c = 0; c < 4; c++) begin
                r1_pa[c] <= r_v1[c*4+2] * ha[c];
                r1_pb[c] <= r_v1[c*4+2] * hb[c];
            end
        end
    end

    // ---- stage 2: view-space z ----
    logic               r2_v;
    lnc_pkg::t_qent     r2_ent;
    logic signed [31:0] r2_za;
    logic signed [31:0] r2_zb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ent <= r1_ent;
            r2_za  <= dot4(r1_pa[0], r1_pa[1], r1_pa[2], r1_pa[3]);
            r2_zb  <= dot4(r1_pb[0], r1_pb[1], r1_pb[2], r1_pb[3]);
        end
    end

    // ---- stage 3: classify against the near plane ----
    logic               r3_v;
    t_tside             r3_side;
    logic [32:0]        r3_rem;
    logic [32:0]        r3_den;
    t_tside             n3_side;
    logic signed [33:0] nearv;
    logic signed [33:0] num;
    logic signed [33:0] den;
    logic signed [33:0] numa;
    logic signed [33:0] dena;

    always_comb begin
        nearv         = -$signed({3'b000, i_cfg.near_distance});
        num           = nearv - 34'(r2_za);
        den           = 34'(r2_zb) - 34'(r2_za);
        numa          = den[33] ? -num : num;
        dena          = den[33] ? -den : den;
        n3_side.ent   = r2_ent;
        n3_side.a_out = 34'(r2_za) > nearv;
        n3_side.b_out = 34'(r2_zb) > nearv;
        for (int i = 0; i < 3; i++) begin
            n3_side.d[i] = 33'($signed(r2_ent.pb[i])) - 33'($signed(r2_ent.pa[i]));
        end
        if (dena == '0 || numa <= '0) begin
            n3_side.tsel = T_ZERO;
        end else if (numa >= dena) begin
            n3_side.tsel = T_ONE;
        end else begin
            n3_side.tsel = T_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_side <= n3_side;
            r3_rem  <= numa[32:0];
            r3_den  <= dena[32:0];
        end
    end

    // ---- clip parameter divide ----
    logic                 t_valid;
    logic [$bits(t_tside)-1:0] t_side_raw;
    logic [0:0][TB-2:0]   t_quo;
    t_tside               t_side;

    lnc_udiv #(
        .LANES (1),
        .DW    (33),
        .QB    (FRAC_BITS),
        .SW    ($bits(t_tside))
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_side  (r3_side),
        .i_rem0  (r3_rem),
        .i_bits  ('0),
        .i_den   (r3_den),
        .o_valid (t_valid),
        .o_side  (t_side_raw),
        .o_quo   (t_quo)
    );

    assign t_side = t_tside'(t_side_raw);

    // ---- stage 4: select t ----
    logic          r4_v;
    t_tside        r4_side;
    logic [TB-1:0] r4_t;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_side <= t_side;
            case (t_side.tsel)
                T_ONE:   r4_t <= TB'(1) << FRAC_BITS;
                T_DIV:   r4_t <= {1'b0, t_quo[0]};
                default: r4_t <= '0;
            endcase
        end
    end

    // ---- stage 5: t * (B - A) ----
    logic               r5_v;
    t_tside             r5_side;
    logic signed [LW-1:0] r5_p [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_side <= r4_side;
            for (int i = 0; i < 3; i++) begin
                r5_p[i] <= $signed({1'b0, r4_t}) * $signed(r4_side.d[i]);
            end
        end
    end

    // ---- stage 6: clipped endpoint replaces the one behind the plane ----
    logic               r6_v;
    lnc_pkg::t_qent     r6_ent;
    logic               r6_drop;
    logic signed [31:0] r6_s [3];
    logic signed [31:0] r6_e [3];
    logic signed [31:0] pt [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt[i] = sat32(72'($signed(r5_side.ent.pa[i])) + 72'(r5_p[i] >>> FRAC_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ent  <= r5_side.ent;
            r6_drop <= r5_side.a_out && r5_side.b_out;
            for (int i = 0; i < 3; i++) begin
                r6_s[i] <= r5_side.a_out ? pt[i] : $signed(r5_side.ent.pa[i]);
                r6_e[i] <= (r5_side.b_out && !r5_side.a_out) ? pt[i]
                                                             : $signed(r5_side.ent.pb[i]);
            end
        end
    end

    // ---- stage 7: full view transform products ----
    logic               r7_v;
    lnc_pkg::t_qent     r7_ent;
    logic               r7_drop;
    logic signed [63:0] r7_ps [4][4];
    logic signed [63:0] r7_pe [4][4];
    logic signed [31:0] hs [4];
    logic signed [31:0] he [4];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            hs[c] = r6_s[c];
            he[c] = r6_e[c];
        end
        hs[3] = ONE_FX;
        he[3] = ONE_FX;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_ent  <= r6_ent;
            r7_drop <= r6_drop;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r7_ps[r][c] <= r_v2[c*4+r] * hs[c];
                    r7_pe[r][c] <= r_v2[c*4+r] * he[c];
                end
            end
        end
    end

    // ---- stage 8: view-space points ----
    logic               r8_v;
    lnc_pkg::t_qent     r8_ent;
    logic               r8_drop;
    logic signed [31:0] r8_vs [4];
    logic signed [31:0] r8_ve [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_ent  <= r7_ent;
            r8_drop <= r7_drop;
            for (int r = 0; r < 4; r++) begin
                r8_vs[r] <= dot4(r7_ps[r][0], r7_ps[r][1], r7_ps[r][2], r7_ps[r][3]);
                r8_ve[r] <= dot4(r7_pe[r][0], r7_pe[r][1], r7_pe[r][2], r7_pe[r][3]);
            end
        end
    end

    // ---- stage 9: projection products for x, y and w rows ----
    logic               r9_v;
    logic [23:0]        r9_color;
    logic [30:0]        r9_lw;
    logic signed [63:0] r9_ps [3][4];
    logic signed [63:0] r9_pe [3][4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_color <= r8_ent.color;
            r9_lw    <= r8_ent.lw;
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 4; c++) begin
                    r9_ps[k][c] <= r_pm[c*4 + ((k == 2) ? 3 : k)] * r8_vs[c];
                    r9_pe[k][c] <= r_pm[c*4 + ((k == 2) ? 3 : k)] * r8_ve[c];
                end
            end
        end
    end

    // ---- stage 10: clip-space x, y, w ----
    logic               r10_v;
    logic [23:0]        r10_color;
    logic [30:0]        r10_lw;
    logic signed [31:0] r10_cs [3];
    logic signed [31:0] r10_ce [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_color <= r9_color;
            r10_lw    <= r9_lw;
            for (int k = 0; k < 3; k++) begin
                r10_cs[k] <= dot4(r9_ps[k][0], r9_ps[k][1], r9_ps[k][2], r9_ps[k][3]);
                r10_ce[k] <= dot4(r9_pe[k][0], r9_pe[k][1], r9_pe[k][2], r9_pe[k][3]);
            end
        end
    end

    // ---- stage 11: magnitudes and signs for the perspective divide ----
    logic                    r11_v;
    t_nside                  r11_side;
    logic [3:0][31:0]        r11_absx;
    logic [3:0][31:0]        r11_absw;
    logic signed [31:0]      lx [4];
    logic signed [31:0]      lw_ [4];
    logic [3:0][QB-1:0]      n_bits;

    always_comb begin
        lx[0]  = r10_cs[0];
        lx[1]  = r10_cs[1];
        lx[2]  = r10_ce[0];
        lx[3]  = r10_ce[1];
        lw_[0] = r10_cs[2];
        lw_[1] = r10_cs[2];
        lw_[2] = r10_ce[2];
        lw_[3] = r10_ce[2];
        for (int l = 0; l < 4; l++) begin
            n_bits[l] = {r11_absx[l], {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_side.color <= r10_color;
            r11_side.lw    <= r10_lw;
            for (int l = 0; l < 4; l++) begin
                r11_absx[l]         <= lx[l][31]  ? 32'(-33'(lx[l]))  : lx[l];
                r11_absw[l]         <= lw_[l][31] ? 32'(-33'(lw_[l])) : lw_[l];
                r11_side.neg[l]     <= lx[l][31] ^ lw_[l][31];
                r11_side.wz[l]      <= (lw_[l] == '0);
                r11_side.xneg[l]    <= lx[l][31];
            end
        end
    end

    // ---- perspective divide, four lanes ----
    logic                      n_valid;
    logic [$bits(t_nside)-1:0] n_side_raw;
    logic [3:0][QB-1:0]        n_quo;
    t_nside                    n_side;

    lnc_udiv #(
        .LANES (4),
        .DW    (32),
        .QB    (QB),
        .SW    ($bits(t_nside))
    ) u_ndiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r11_v),
        .i_side  (r11_side),
        .i_rem0  ('0),
        .i_bits  (n_bits),
        .i_den   (r11_absw),
        .o_valid (n_valid),
        .o_side  (n_side_raw),
        .o_quo   (n_quo)
    );

    assign n_side = t_nside'(n_side_raw);

    // ---- stage 12: signed, clamped ndc plus one ----
    logic               r12_v;
    logic [23:0]        r12_color;
    logic [30:0]        r12_lw;
    logic signed [NW-1:0] r12_n [4];
    logic [MW-1:0]      mag [4];
    logic signed [NW-1:0] ndc [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            mag[l] = (MW'(n_quo[l]) > NDC_LIM) ? NDC_LIM : MW'(n_quo[l]);
            if (n_side.wz[l]) begin
                ndc[l] = n_side.xneg[l] ? -$signed(NW'(NDC_LIM)) : $signed(NW'(NDC_LIM));
            end else begin
                ndc[l] = n_side.neg[l] ? -$signed(NW'(mag[l])) : $signed(NW'(mag[l]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_color <= n_side.color;
            r12_lw    <= n_side.lw;
            for (int l = 0; l < 4; l++) begin
                r12_n[l] <= ndc[l] + NW'(ONE_FX);
            end
        end
    end

    // ---- stage 13: scale by viewport size ----
    logic                  r13_v;
    logic [23:0]           r13_color;
    logic [30:0]           r13_lw;
    logic signed [SW_-1:0] r13_p [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r13_color <= r12_color;
            r13_lw    <= r12_lw;
            for (int l = 0; l < 4; l++) begin
                r13_p[l] <= r12_n[l] * $signed({1'b0, ((l % 2) == 0) ? i_cfg.display_width
                                                                     : i_cfg.display_height});
            end
        end
    end

    // ---- valid chain ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r6_v        <= 1'b0;
            r7_v        <= 1'b0;
            r8_v        <= 1'b0;
            r9_v        <= 1'b0;
            r10_v       <= 1'b0;
            r11_v       <= 1'b0;
            r12_v       <= 1'b0;
            r13_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_v        <= i_q_valid;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= t_valid;
            r5_v        <= r4_v;
            r6_v        <= r5_v;
            r7_v        <= r6_v;
            r8_v        <= r7_v;
            // only lines that survive the near plane go on past here
            r9_v        <= r8_v && (r8_ent.kind == lnc_pkg::K_DRAW) && !r8_drop;
            r10_v       <= r9_v;
            r11_v       <= r10_v;
            r12_v       <= n_valid;
            r13_v       <= r12_v;
            r_out_valid <= r13_v;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_item.screen_start_x <= sat32(72'(r13_p[0] >>> 1));
            r_out_item.screen_start_y <= sat32(72'(r13_p[1] >>> 1));
            r_out_item.screen_end_x   <= sat32(72'(r13_p[2] >>> 1));
            r_out_item.screen_end_y   <= sat32(72'(r13_p[3] >>> 1));
            r_out_item.packed_color   <= {lnc_pkg::ALPHA_OPAQUE, r13_color};
            r_out_item.out_width      <= r13_lw;
        end
    end

    // ---- matrix copies: each updated as the load beat passes its reader ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                r_v1[k] <= '0;
                r_v2[k] <= '0;
                r_pm[k] <= '0;
            end
        end else if (en) begin
            if (i_q_valid && i_q_ent.kind == lnc_pkg::K_VIEW) begin
                r_v1[i_q_ent.idx] <= $signed(i_q_ent.value);
            end
            if (r6_v && r6_ent.kind == lnc_pkg::K_VIEW) begin
                r_v2[r6_ent.idx] <= $signed(r6_ent.value);
            end
            if (r8_v && r8_ent.kind == lnc_pkg::K_PROJ) begin
                r_pm[r8_ent.idx] <= $signed(r8_ent.value);
            end
        end
    end

endmodule

/* rtl/core/lnc_checker.sv */
// ----------------------------------------------------------------------------
// lnc_checker: port-level checks for the line clip and projection core
// Bound to the top level; watches output beats and the config port.
// ----------------------------------------------------------------------------
module lnc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input lnc_pkg::t_out_item o_item,
    input logic [3:0]         paddr,
    input logic [31:0]        prdata,
    input logic               pready
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("output beat changed under stall");

    // every line carries an opaque alpha
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.packed_color[31:24] == lnc_pkg::ALPHA_OPAQUE)
        else $error("alpha byte not opaque");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // size registers read back within their width
    a_size_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (paddr[3:2] == lnc_pkg::REG_WIDTH || paddr[3:2] == lnc_pkg::REG_HEIGHT)
        |-> prdata[31:14] == '0 && pready)
        else $error("size register read back too wide");

endmodule

bind line_near_clip_and_screen_project_core lnc_checker u_lnc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item),
    .paddr   (paddr),
    .prdata  (prdata),
    .pready  (pready)
);

/* tb/lnc_checker.sv */
// ----------------------------------------------------------------------------
// lnc_tb_checker: output predictor and comparator for the line clip core
// Watches both beat channels and the config port, models the matrices, clip
// and projection in fixed point, and compares each output beat in order.
// ----------------------------------------------------------------------------
module lnc_tb_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  lnc_pkg::t_in_item  i_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  lnc_pkg::t_out_item i_out_item,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [3:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam int FB = lnc_pkg::FRAC_BITS_DEF;
    localparam longint ONE = longint'(1) << FB;
    localparam longint NDC_MAX = longint'(1) << lnc_pkg::NDC_LIMIT_LOG2;

    logic signed [31:0] view_m [16];
    logic signed [31:0] proj_m [16];
    logic [30:0] near_dist;
    logic [13:0] disp_w, disp_h;
    lnc_pkg::t_out_item expected_segments [$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_segments.size();

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // arithmetic shift right is a floor for signed values
    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void mat_mul(input logic signed [31:0] m [16],
                                    input longint v [4], output longint o [4]);
        longint acc;
        for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int c = 0; c < 4; c++)
                acc += fl_shift(longint'(m[c*4+r]) * v[c], FB);
            o[r] = sat32(acc);
        end
    endfunction

    function automatic longint pixel_of(longint x, longint w, longint size);
        longint ndc;
        if (w == 0) begin
            ndc = (x >= 0) ? NDC_MAX : -NDC_MAX;
        end else begin
            ndc = (x * ONE) / w;
            if (ndc > NDC_MAX) ndc = NDC_MAX;
            if (ndc < -NDC_MAX) ndc = -NDC_MAX;
        end
        return sat32(fl_shift((ndc + ONE) * size, 1));
    endfunction

    function automatic void to_pixels(input longint p [3], output longint sx,
                                      output longint sy);
        longint h [4], vs [4], cs [4];
        h[0] = p[0]; h[1] = p[1]; h[2] = p[2]; h[3] = ONE;
        mat_mul(view_m, h, vs);
        mat_mul(proj_m, vs, cs);
        sx = pixel_of(cs[0], cs[3], longint'(disp_w));
        sy = pixel_of(cs[1], cs[3], longint'(disp_h));
    endfunction

    // Clip a line at the near plane and queue its screen segment, if any remains
    function automatic void predict_segment(lnc_pkg::t_in_item it);
        longint a [3], b [3], s [3], e [3], ha [4], hb [4], va [4], vb [4];
        longint nearv, num, den, t, pt, sx0, sy0, sx1, sy1;
        logic a_out, b_out;
        lnc_pkg::t_out_item r;
        a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
        b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
        for (int i = 0; i < 3; i++) begin
            ha[i] = a[i]; hb[i] = b[i]; s[i] = a[i]; e[i] = b[i];
        end
        ha[3] = ONE; hb[3] = ONE;
        mat_mul(view_m, ha, va);
        mat_mul(view_m, hb, vb);
        nearv = -longint'(near_dist);
        a_out = va[2] > nearv;
        b_out = vb[2] > nearv;
        if (a_out && b_out) return;
        if (a_out || b_out) begin
            num = nearv - va[2];
            den = vb[2] - va[2];
            if (den < 0) begin
                num = -num; den = -den;
            end
            if (den == 0 || num <= 0) t = 0;
            else if (num >= den) t = ONE;
            else t = (num << FB) / den;
            for (int i = 0; i < 3; i++) begin
                pt = sat32(a[i] + fl_shift(t * (b[i] - a[i]), FB));
                if (a_out) s[i] = pt;
                else e[i] = pt;
            end
        end
        to_pixels(s, sx0, sy0);
        to_pixels(e, sx1, sy1);
        r.screen_start_x = sx0[31:0];
        r.screen_start_y = sy0[31:0];
        r.screen_end_x   = sx1[31:0];
        r.screen_end_y   = sy1[31:0];
        r.packed_color   = {lnc_pkg::ALPHA_OPAQUE, it.color_rgb};
        r.out_width      = it.line_width;
        expected_segments.insert(expected_segments.size(), r);
    endfunction

    always @(posedge i_clk) begin
        lnc_pkg::t_out_item want;
        if (!i_rst_n) begin
            foreach (view_m[k]) begin
                view_m[k] = '0;
                proj_m[k] = '0;
            end
            near_dist = lnc_pkg::NEAR_RESET;
            disp_w    = lnc_pkg::WIDTH_RESET;
            disp_h    = lnc_pkg::HEIGHT_RESET;
            fails     = 0;
            expected_segments.delete();
        end else begin
            // config writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    lnc_pkg::REG_NEAR:   near_dist = i_pwdata[30:0];
                    lnc_pkg::REG_WIDTH:  disp_w    = i_pwdata[13:0];
                    lnc_pkg::REG_HEIGHT: disp_h    = i_pwdata[13:0];
                    default: ;
                endcase
            end
            // output beat compare
            if (i_out_valid && !i_out_stall) begin
                if (expected_segments.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected output beat %h", i_out_item);
                end else begin
                    want = expected_segments.pop_front();
                    if (want !== i_out_item) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp %h %h %h %h %h %h got %h %h %h %h %h %h",
                                want.screen_start_x, want.screen_start_y,
                                want.screen_end_x, want.screen_end_y,
                                want.packed_color, want.out_width,
                                i_out_item.screen_start_x, i_out_item.screen_start_y,
                                i_out_item.screen_end_x, i_out_item.screen_end_y,
                                i_out_item.packed_color, i_out_item.out_width);
                    end
                end
            end
            // input beat
            if (i_valid && !i_in_stall) begin
                case (i_item.cmd)
                    lnc_pkg::CMD_LOAD_VIEW:
                        view_m[i_item.element_index] = i_item.element_value;
                    lnc_pkg::CMD_LOAD_PROJ:
                        proj_m[i_item.element_index] = i_item.element_value;
                    lnc_pkg::CMD_DRAW: predict_segment(i_item);
                    default: ;
                endcase
            end
        end
    end
endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the near-plane line clip and projection core
// Loads matrices, draws directed and random lines through several config
// settings and idle patterns; a checker beside the core compares results.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY = 2 * lnc_pkg::FRAC_BITS_DEF + 49;
    localparam int WATCHDOG = 20000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic               clk, rst_n;
    logic               in_valid, in_stall, out_valid, out_stall;
    lnc_pkg::t_in_item  in_item;
    lnc_pkg::t_out_item out_item;
    logic               psel, penable, pwrite, pready;
    logic [3:0]         paddr;
    logic [31:0]        pwdata, prdata;
    int                 fail_count, pending;
    int                 send_idle_pct, recv_stall_pct;
    int                 quiet_cycles;

    line_near_clip_and_screen_project_core u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_item(in_item),
        .o_valid(out_valid), .i_stall(out_stall), .o_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lnc_tb_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_in_stall(in_stall), .i_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stall pattern
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // drive one beat, holding it until taken; valid stays up for the caller
    task automatic send_beat(lnc_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return $signed($urandom_range(8 << 16)) - (4 << 16);
        endcase
    endfunction

    task automatic load_elem(logic [1:0] cmd, int idx, logic [31:0] val);
        lnc_pkg::t_in_item it;
        it = '{default: '0};
        it.cmd = cmd; it.element_index = idx[3:0]; it.element_value = val;
        it.a_x = $urandom(); it.line_width = 31'($urandom());
        send_beat(it);
    endtask

    // camera looking down -z with a simple perspective projection
    task automatic load_camera(bit noisy);
        int nv;
        for (int k = 0; k < 16; k++) begin
            nv = (k % 5 == 0) ? 32'h0001_0000 : 0;
            if (noisy && $urandom_range(3) == 0) nv = rand_val();
            load_elem(lnc_pkg::CMD_LOAD_VIEW, k, nv);
        end
        for (int k = 0; k < 16; k++) begin
            case (k)
                0, 5, 10: nv = 32'h0001_0000;
                11:       nv = 32'hFFFF_0000;
                14:       nv = 32'hFFFE_0000;
                default:  nv = 0;
            endcase
            if (noisy && $urandom_range(3) == 0) nv = rand_val();
            load_elem(lnc_pkg::CMD_LOAD_PROJ, k, nv);
        end
    endtask

    function automatic lnc_pkg::t_in_item rand_line();
        lnc_pkg::t_in_item it;
        it.cmd = lnc_pkg::CMD_DRAW;
        it.element_index = 4'($urandom()); it.element_value = $urandom();
        it.a_x = rand_val(); it.a_y = rand_val(); it.a_z = rand_val();
        it.b_x = rand_val(); it.b_y = rand_val(); it.b_z = rand_val();
        it.color_rgb = 24'($urandom()); it.line_width = 31'($urandom());
        return it;
    endfunction

    initial begin
        lnc_pkg::t_in_item it;
        int pick;
        rst_n = 1'b0; in_valid = 1'b0; in_item = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero matrices first: the line maps to view z of zero and is dropped at the near plane
        it = rand_line();
        send_beat(it);
        load_camera(1'b0);

        // directed: crossing, behind, in front, extremes, unused command
        it = rand_line(); it.a_z = -32'sh0005_0000; it.b_z = 32'sh0002_0000;
        it.color_rgb = '1; it.line_width = '1; send_beat(it);
        it = rand_line(); it.a_z = 32'sh0002_0000; it.b_z = -32'sh0005_0000;
        it.color_rgb = '0; it.line_width = '0; send_beat(it);
        it = rand_line(); it.a_z = -32'sh0003_0000; it.b_z = -32'sh0007_0000;
        send_beat(it);
        it = rand_line(); it.a_z = 32'sh0001_0000; it.b_z = 32'sh0003_0000;
        send_beat(it);
        it = rand_line(); it.a_x = 32'h8000_0000; it.a_y = 32'h7FFF_FFFF;
        it.a_z = 32'h8000_0000; it.b_x = 32'h7FFF_FFFF; it.b_y = 32'h8000_0000;
        it.b_z = 32'h7FFF_FFFF; send_beat(it);
        it = rand_line(); it.a_z = 0; it.b_z = 0; send_beat(it);
        it = rand_line(); it.cmd = CMD_UNUSED; send_beat(it);
        it = rand_line(); it.element_index = 4'hF; send_beat(it);
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            case (ph)
                0: begin reg_write(lnc_pkg::REG_NEAR, 32'd1);
                         reg_write(lnc_pkg::REG_WIDTH, 32'd1);
                         reg_write(lnc_pkg::REG_HEIGHT, 32'd1); end
                1: begin reg_write(lnc_pkg::REG_NEAR, 32'h7FFF_FFFF);
                         reg_write(lnc_pkg::REG_WIDTH, 32'd8192);
                         reg_write(lnc_pkg::REG_HEIGHT, 32'd8192); end
                2: begin reg_write(lnc_pkg::REG_NEAR, 32'hFFFF_FFFF);
                         reg_write(lnc_pkg::REG_WIDTH, 32'hFFFF_FFFF);
                         reg_write(lnc_pkg::REG_HEIGHT, 32'hFFFF_C000); end
                default: begin reg_write(lnc_pkg::REG_NEAR, $urandom_range(1, 4 << 16));
                         reg_write(lnc_pkg::REG_WIDTH, $urandom_range(1, 8192));
                         reg_write(lnc_pkg::REG_HEIGHT, $urandom_range(1, 8192)); end
            endcase
            if (ph % 3 == 1) load_camera(1'b1);
            else if (ph == 4) load_camera(1'b0);
            for (int n = 0; n < 220; n++) begin
                pick = $urandom_range(99);
                if (pick < 4) begin
                    load_elem(lnc_pkg::CMD_LOAD_VIEW, $urandom_range(15), rand_val());
                end else if (pick < 8) begin
                    load_elem(lnc_pkg::CMD_LOAD_PROJ, $urandom_range(15), rand_val());
                end else begin
                    it = rand_line();
                    if (pick < 11) it.cmd = CMD_UNUSED;
                    send_beat(it);
                end
                // pause until every outstanding segment is out
                if (n == 100 && ph == 0) begin
                    in_valid <= 1'b0;
                    @(negedge clk);
                    while (pending != 0) @(negedge clk);
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/lnc_pkg.sv
rtl/core/lnc_front.sv
rtl/core/lnc_fifo.sv
rtl/core/lnc_udiv.sv
rtl/core/lnc_back.sv
rtl/core/line_near_clip_and_screen_project_core.sv
rtl/core/lnc_checker.sv
tb/lnc_checker.sv
tb/tb_top.sv
